[hdl/rrts_pkg.sv]
// Shared types and codes for the round-robin task scheduler.
`default_nettype none

package rrts_pkg;

  // Task mode as held in the task table
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_READY   = 2'd0;
  localparam mode_t MODE_RUNNING = 2'd1;
  localparam mode_t MODE_BLOCKED = 2'd2;

  // Request function codes
  typedef logic [1:0] func_t;

  localparam func_t FUNC_TICK   = 2'd0;
  localparam func_t FUNC_DELAY  = 2'd1;
  localparam func_t FUNC_SWITCH = 2'd2;

  // Shared adder operations
  typedef logic alu_op_t;

  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

  localparam int TIME_W = 32;

endpackage

`default_nettype wire

[hdl/rrts_alu.sv]
// Shared 32-bit adder/subtractor used for tick advance, wake time and wake compare.
`default_nettype none

module rrts_alu (
  input  wire rrts_pkg::alu_op_t op,
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output logic [31:0]            sum,
  output logic                   carry
);
  import rrts_pkg::*;

  logic [31:0] b_eff;
  logic [32:0] total;

  // Subtract as a plus inverted b plus one; carry out means a >= b
  assign b_eff = (op == ALU_SUB) ? ~b : b;
  assign total = {1'b0, a} + {1'b0, b_eff} + {32'd0, (op == ALU_SUB)};
  assign sum   = total[31:0];
  assign carry = total[32];

endmodule

`default_nettype wire

[hdl/rrts_fifo.sv]
// Circular ready queue of task ids with its slot memory.
`default_nettype none

module rrts_fifo #(
  parameter int TASKS = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [$clog2(TASKS)-1:0]     push_id,
  input  wire logic                         pop,
  output logic [$clog2(TASKS)-1:0]          pop_id,
  output logic [$clog2(TASKS+1)-1:0]        fill
);
  import rrts_pkg::*;

  localparam int ID_W   = $clog2(TASKS);
  localparam int FILL_W = $clog2(TASKS + 1);
  localparam logic [ID_W-1:0]   LAST_SLOT = ID_W'(TASKS - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(TASKS);

  logic [ID_W-1:0] slots [TASKS];
  logic [TASKS-1:0] slot_valid;
  logic [ID_W-1:0] head;
  logic [ID_W-1:0] tail;
  logic            push_ok;
  logic            pop_ok;
  logic [ID_W-1:0] head_init;

  // Refuse a push when full, ignore a pop when empty
  assign push_ok = push && (fill != FULL);
  assign pop_ok  = pop && (fill != '0);

  // Start-up contents: slot i holds i+1, the last slot holds idle
  assign head_init = (head == LAST_SLOT) ? '0 : head + ID_W'(1);

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= LAST_SLOT;
      fill       <= FILL_W'(TASKS - 1);
      slot_valid <= '0;
    end else begin
      if (push_ok) begin
        tail             <= (tail == LAST_SLOT) ? '0 : tail + ID_W'(1);
        slot_valid[tail] <= 1'b1;
      end
      if (pop_ok) begin
        head <= (head == LAST_SLOT) ? '0 : head + ID_W'(1);
      end
      if (push_ok && !pop_ok) begin
        fill <= fill + FILL_W'(1);
      end else if (pop_ok && !push_ok) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  // Slot memory write
  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[tail] <= push_id;
    end
  end

  // Registered read of the head slot
  always_ff @(posedge clk) begin
    if (pop_ok) begin
      pop_id <= slot_valid[head] ? slots[head] : head_init;
    end
  end

endmodule

`default_nettype wire

[hdl/rrts_task_table.sv]
// Per-task mode and wake time memories with one registered read port.
`default_nettype none

module rrts_task_table #(
  parameter int TASKS = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [$clog2(TASKS)-1:0]  rd_addr,
  output rrts_pkg::mode_t                mode_q,
  output logic [31:0]                    wake_q,
  input  wire logic [$clog2(TASKS)-1:0]  wr_addr,
  input  wire logic                      mode_we,
  input  wire rrts_pkg::mode_t           mode_wd,
  input  wire logic                      wake_we,
  input  wire logic [31:0]               wake_wd
);
  import rrts_pkg::*;

  mode_t       modes [TASKS];
  logic [31:0] wakes [TASKS];
  logic [TASKS-1:0] mode_valid;

  // Mark written modes; an unwritten task reads as ready
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_valid <= '0;
    end else if (mode_we) begin
      mode_valid[wr_addr] <= 1'b1;
    end
  end

  // Memory writes
  always_ff @(posedge clk) begin
    if (mode_we) begin
      modes[wr_addr] <= mode_wd;
    end
    if (wake_we) begin
      wakes[wr_addr] <= wake_wd;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mode_q <= mode_valid[rd_addr] ? modes[rd_addr] : MODE_READY;
      wake_q <= wakes[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/round_robin_task_scheduler.sv]
// Top level of the round-robin task scheduler: sequencer, tick counter and outputs.
`default_nettype none

// Hardware round-robin scheduler for TASKS tasks, task 0 being idle. Each request
// (tick, delay-then-switch, or switch) yields exactly one result with the task now
// running, the ready queue depth, the tasks woken by a tick and a flag for a delay
// asked while idle. One request is worked on at a time and in_ready is high only
// between requests. On a tick one shared 32-bit adder advances the counter, then
// compares each task's wake time, reading then comparing one task at a time, as the
// task table is read through one registered memory port. A switch requeues a
// running real task and pops the next; a delay forms the wake time, then switches.
// A delay while idle or an unused code skips to the result.
// A finished result waits in the output register while the next request is taken in.
module round_robin_task_scheduler #(
  parameter int TASKS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] delay_ticks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       current_task,
  output logic [2:0]       ready_count,
  output logic [1:0]       woken_count,
  output logic             delay_ignored
);
  import rrts_pkg::*;

  localparam int ID_W   = $clog2(TASKS);
  localparam int FILL_W = $clog2(TASKS + 1);
  localparam logic [ID_W-1:0] LAST_TASK = ID_W'(TASKS - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_INC   = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_CMP   = 4'd3;
  localparam logic [3:0] ST_DADD  = 4'd4;
  localparam logic [3:0] ST_SWRD  = 4'd5;
  localparam logic [3:0] ST_SWCHK = 4'd6;
  localparam logic [3:0] ST_SWPOP = 4'd7;
  localparam logic [3:0] ST_SWSET = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]        state;
  logic [31:0]       tick_count;
  logic [31:0]       delay_r;
  logic [ID_W-1:0]   running_id;
  logic [ID_W-1:0]   scan_idx;
  logic [1:0]        woken;
  logic              ignored;
  logic              popped;

  alu_op_t           alu_op;
  logic [31:0]       alu_a;
  logic [31:0]       alu_b;
  logic [31:0]       alu_sum;
  logic              alu_carry;

  logic              rd_en;
  logic [ID_W-1:0]   rd_addr;
  mode_t             mode_q;
  logic [31:0]       wake_q;
  logic [ID_W-1:0]   wr_addr;
  logic              mode_we;
  mode_t             mode_wd;
  logic              wake_we;

  logic              fifo_push;
  logic [ID_W-1:0]   push_id;
  logic              fifo_pop;
  logic [ID_W-1:0]   pop_id;
  logic [FILL_W-1:0] fill;

  logic [ID_W-1:0]   next_id;
  logic              wake_due;
  logic              out_load;

  assign in_ready = (state == ST_IDLE);
  assign next_id  = popped ? pop_id : '0;
  assign wake_due = (mode_q == MODE_BLOCKED) && alu_carry;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // Shared adder
  rrts_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  rrts_task_table #(.TASKS(TASKS)) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .mode_q  (mode_q),
    .wake_q  (wake_q),
    .wr_addr (wr_addr),
    .mode_we (mode_we),
    .mode_wd (mode_wd),
    .wake_we (wake_we),
    .wake_wd (alu_sum)
  );

  rrts_fifo #(.TASKS(TASKS)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (fifo_push),
    .push_id (push_id),
    .pop     (fifo_pop),
    .pop_id  (pop_id),
    .fill    (fill)
  );

  // Steer the adder: advance, compare against wake time, or form wake time
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = tick_count;
    alu_b  = 32'd1;
    case (state)
      ST_CMP: begin
        alu_op = ALU_SUB;
        alu_b  = wake_q;
      end
      ST_DADD: begin
        alu_a = delay_r;
        alu_b = tick_count;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // Drive table and queue strobes from the sequencer
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = running_id;
    wr_addr   = running_id;
    mode_we   = 1'b0;
    mode_wd   = MODE_READY;
    wake_we   = 1'b0;
    fifo_push = 1'b0;
    push_id   = running_id;
    fifo_pop  = 1'b0;
    case (state)
      ST_RD: begin
        rd_en   = 1'b1;
        rd_addr = scan_idx;
      end
      ST_CMP: begin
        wr_addr   = scan_idx;
        push_id   = scan_idx;
        mode_we   = wake_due;
        fifo_push = wake_due && (scan_idx != '0);
      end
      ST_DADD: begin
        mode_we = 1'b1;
        mode_wd = MODE_BLOCKED;
        wake_we = 1'b1;
      end
      ST_SWRD: begin
        rd_en = 1'b1;
      end
      ST_SWCHK: begin
        mode_we   = (mode_q == MODE_RUNNING);
        fifo_push = (mode_q == MODE_RUNNING);
      end
      ST_SWPOP: begin
        fifo_pop = 1'b1;
      end
      ST_SWSET: begin
        wr_addr = next_id;
        mode_we = 1'b1;
        mode_wd = MODE_RUNNING;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Sequencer and scheduler registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      running_id <= ID_W'(1);
      scan_idx   <= '0;
      woken      <= '0;
      ignored    <= 1'b0;
      popped     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            delay_r <= delay_ticks;
            woken   <= '0;
            ignored <= 1'b0;
            case (func)
              FUNC_TICK: begin
                state <= ST_INC;
              end
              FUNC_DELAY: begin
                if (running_id != '0) begin
                  state <= ST_DADD;
                end else begin
                  ignored <= 1'b1;
                  state   <= ST_DONE;
                end
              end
              FUNC_SWITCH: begin
                state <= (running_id != '0) ? ST_SWRD : ST_SWPOP;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_INC: begin
          tick_count <= alu_sum;
          scan_idx   <= '0;
          state      <= ST_RD;
        end
        ST_RD: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (wake_due) begin
            woken <= woken + 2'd1;
          end
          if (scan_idx == LAST_TASK) begin
            state <= ST_DONE;
          end else begin
            scan_idx <= scan_idx + ID_W'(1);
            state    <= ST_RD;
          end
        end
        ST_DADD: begin
          state <= ST_SWRD;
        end
        ST_SWRD: begin
          state <= ST_SWCHK;
        end
        ST_SWCHK: begin
          state <= ST_SWPOP;
        end
        ST_SWPOP: begin
          popped <= (fill != '0);
          state  <= ST_SWSET;
        end
        ST_SWSET: begin
          running_id <= next_id;
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      current_task  <= 2'(running_id);
      ready_count   <= 3'(fill);
      woken_count   <= woken;
      delay_ignored <= ignored;
    end
  end

  // The queue never holds more ids than there are tasks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(TASKS))
    else $error("ready queue fill exceeds task count");

  // A finished request always lands in the output register
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == ST_IDLE))
    else $error("finished request not presented");

  // A refused delay only happens while idle runs
  a_ignored_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && delay_ignored |-> current_task == 2'd0 && woken_count == 2'd0)
    else $error("delay refused while a real task runs");

endmodule

`default_nettype wire
